// ===== sv/tsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tsa_pkg: shared types and helpers for TCP segment arrival
// Connection state codes, result codes, the classified item carried from the
// front to the back, and modulo-2^32 sequence compares.
// ----------------------------------------------------------------------------
package tsa_pkg;

  localparam int unsigned QDepth = 2;

  localparam logic [15:0] OffsetMask = 16'hF000;
  localparam int unsigned FlagFin = 0;
  localparam int unsigned FlagSyn = 1;
  localparam int unsigned FlagRst = 2;
  localparam int unsigned FlagAck = 4;

  typedef enum logic [3:0] {
    ST_CLOSED     = 4'd0,
    ST_LISTEN     = 4'd1,
    ST_SYN_SENT   = 4'd2,
    ST_SYN_RCVD   = 4'd3,
    ST_EST        = 4'd4,
    ST_FW1        = 4'd5,
    ST_FW2        = 4'd6,
    ST_CLOSE_WAIT = 4'd7,
    ST_CLOSING    = 4'd8,
    ST_LAST_ACK   = 4'd9,
    ST_TIME_WAIT  = 4'd10
  } tsa_state_e;

  typedef enum logic [2:0] {
    ACT_DROP    = 3'd0,
    ACT_PASS    = 3'd1,
    ACT_ACK     = 3'd2,
    ACT_FIN_ACK = 3'd3,
    ACT_LISTEN  = 3'd4
  } tsa_action_e;

  typedef enum logic [2:0] {
    SIG_NONE    = 3'd0,
    SIG_REFUSED = 3'd1,
    SIG_RESET   = 3'd2,
    SIG_CLOSING = 3'd3,
    SIG_INTR    = 3'd4
  } tsa_signal_e;

  typedef enum logic [2:0] {
    REG_RCV_NEXT    = 3'd0,
    REG_RCV_WINDOW  = 3'd1,
    REG_SEND_NEXT   = 3'd2,
    REG_START_STATE = 3'd3,
    REG_START_UNA   = 3'd4,
    REG_START_WND   = 3'd5,
    REG_START_WL1   = 3'd6,
    REG_START_WL2   = 3'd7
  } tsa_reg_e;

  // Static connection parameters; users write them only while idle, unchecked.
  typedef struct packed {
    logic [31:0] rcv_next;
    logic [15:0] rcv_window;
    logic [31:0] send_next;
  } tsa_cfg_t;

  // Load strobes for the back's state registers.
  typedef struct packed {
    logic        state;
    logic        una;
    logic        wnd;
    logic        wl1;
    logic        wl2;
    logic [31:0] value;
  } tsa_load_t;

  // Classified segment: ok folds the length check and acceptability test.
  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] window;
    logic        fin;
    logic        syn;
    logic        rst;
    logic        ack_flag;
    logic        ok;
  } tsa_item_t;

  typedef struct packed {
    tsa_action_e action;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack;
    tsa_signal_e user_signal;
    logic        remove_socket;
    logic [3:0]  new_state;
  } tsa_result_t;

  function automatic logic seq_lt(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

  function automatic logic seq_le(logic [31:0] a, logic [31:0] b);
    return (a == b) || seq_lt(a, b);
  endfunction

endpackage

// ===== sv/tsa_front.sv =====
// ----------------------------------------------------------------------------
// tsa_front: segment classifier
// Registers one segment per cycle unless the queue is full, together with
// its length check and receive-window acceptability verdict.
// ----------------------------------------------------------------------------
module tsa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsa_pkg::tsa_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       seg_seq_i,
  input  logic [31:0]       seg_ack_i,
  input  logic [15:0]       seg_window_i,
  input  logic [15:0]       hdr_word_i,
  input  logic [15:0]       l4_length_i,
  output logic              push_o,
  output tsa_pkg::tsa_item_t item_o,
  input  logic              q_full_i
);
  import tsa_pkg::*;

  logic        valid_q;
  tsa_item_t   item_q, item_d;
  logic [15:0] offset_bits;
  logic [5:0]  hlen;
  logic        short_seg;
  logic [15:0] slen;
  logic        slen_nz;
  logic [31:0] end_seg;
  logic [31:0] end_win;
  logic        win_zero;
  logic        accept_in;
  logic        hit_start;
  logic        hit_end;

  assign push_o     = valid_q && !q_full_i;
  assign in_stall_o = valid_q && q_full_i;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign item_o     = item_q;

  always_comb begin
    offset_bits = hdr_word_i & OffsetMask;
    hlen        = {offset_bits[15:12], 2'b00};
    short_seg   = l4_length_i < {10'd0, hlen};
    slen        = l4_length_i - {10'd0, hlen};
    slen_nz     = slen != 16'd0;
    end_seg     = seg_seq_i + {16'd0, slen} - {31'd0, slen_nz};
    win_zero    = cfg_i.rcv_window == 16'd0;
    end_win     = cfg_i.rcv_next + (win_zero ? 32'd1 : {16'd0, cfg_i.rcv_window});
    hit_start   = seq_le(cfg_i.rcv_next, seg_seq_i) && seq_lt(seg_seq_i, end_win);
    hit_end     = seq_le(cfg_i.rcv_next, end_seg) && seq_lt(end_seg, end_win);

    item_d.seq      = seg_seq_i;
    item_d.ack      = seg_ack_i;
    item_d.window   = seg_window_i;
    item_d.fin      = hdr_word_i[FlagFin];
    item_d.syn      = hdr_word_i[FlagSyn];
    item_d.rst      = hdr_word_i[FlagRst];
    item_d.ack_flag = hdr_word_i[FlagAck];
    item_d.ok       = !short_seg && !(win_zero && slen_nz) && (hit_start || hit_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept_in) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== sv/tsa_queue.sv =====
// ----------------------------------------------------------------------------
// tsa_queue: classified-item queue
// Two-entry FIFO that decouples the classifier from the state update.
// ----------------------------------------------------------------------------
module tsa_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tsa_pkg::tsa_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               not_empty_o,
  output tsa_pkg::tsa_item_t head_item_o
);
  import tsa_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  tsa_item_t       entry_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o      = count_q == (PtrW+1)'(QDepth);
  assign not_empty_o = count_q != '0;
  assign head_item_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/tsa_back.sv =====
// ----------------------------------------------------------------------------
// tsa_back: connection state update
// Holds the connection state and send variables, applies one classified
// segment per cycle unless the output stalls, and registers its result.
// ----------------------------------------------------------------------------
module tsa_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsa_pkg::tsa_cfg_t   cfg_i,
  input  tsa_pkg::tsa_load_t  load_i,
  input  logic                head_valid_i,
  input  tsa_pkg::tsa_item_t  head_item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tsa_pkg::tsa_result_t result_o
);
  import tsa_pkg::*;

  tsa_state_e  state_q, state_d;
  logic [31:0] una_q, una_d;
  logic [15:0] wnd_q, wnd_d;
  logic [31:0] wl1_q, wl1_d;
  logic [31:0] wl2_q, wl2_d;
  logic        out_valid_q;
  tsa_result_t result_q, result_d;
  logic        fin_go;
  logic        finished;
  logic        sync_ack_state;

  assign pop_o       = head_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  always_comb begin
    state_d  = state_q;
    una_d    = una_q;
    wnd_d    = wnd_q;
    wl1_d    = wl1_q;
    wl2_d    = wl2_q;
    fin_go   = 1'b0;
    finished = 1'b0;
    sync_ack_state = (state_q >= ST_EST) && (state_q <= ST_CLOSING);

    result_d.action        = ACT_DROP;
    result_d.reply_seq     = '0;
    result_d.reply_ack     = '0;
    result_d.user_signal   = SIG_NONE;
    result_d.remove_socket = 1'b0;

    if (state_q == ST_LISTEN) begin
      result_d.action = ACT_LISTEN;
    end else if (state_q == ST_CLOSED || state_q == ST_SYN_SENT || state_q > ST_TIME_WAIT) begin
      result_d.action = ACT_DROP;
    end else if (!head_item_i.ok) begin
      result_d.action = ACT_DROP;
    end else if (head_item_i.rst) begin
      // Signal depends on how far the connection had come.
      if (state_q == ST_SYN_RCVD) begin
        result_d.user_signal = SIG_REFUSED;
      end else if (state_q >= ST_EST && state_q <= ST_CLOSE_WAIT) begin
        result_d.user_signal = SIG_RESET;
      end else begin
        result_d.user_signal = SIG_INTR;
      end
      result_d.remove_socket = 1'b1;
      state_d = ST_CLOSED;
    end else if (head_item_i.syn) begin
      result_d.user_signal   = SIG_RESET;
      result_d.remove_socket = 1'b1;
      state_d = ST_CLOSED;
    end else begin
      fin_go = head_item_i.fin;
      if (head_item_i.ack_flag) begin
        if (sync_ack_state) begin
          if (seq_lt(cfg_i.send_next, head_item_i.ack)) begin
            // Ack of unsent data: answer with an ACK, skip FIN.
            result_d.action    = ACT_ACK;
            result_d.reply_seq = cfg_i.rcv_next;
            result_d.reply_ack = cfg_i.send_next;
            fin_go   = 1'b0;
            finished = 1'b1;
          end else if (!seq_lt(head_item_i.ack, una_q)) begin
            una_d = head_item_i.ack;
            if (seq_lt(wl1_q, head_item_i.seq) ||
                (wl1_q == head_item_i.seq && seq_le(wl2_q, head_item_i.ack))) begin
              wnd_d = head_item_i.window;
              wl1_d = head_item_i.seq;
              wl2_d = head_item_i.ack;
            end
            if (state_q == ST_FW1) begin
              state_d = ST_FW2;
            end else if (state_q == ST_CLOSING) begin
              state_d = ST_TIME_WAIT;
            end
          end
        end else if (state_q == ST_LAST_ACK) begin
          state_d = ST_CLOSED;
        end
      end else if (!head_item_i.fin) begin
        finished = 1'b1;
      end

      if (fin_go) begin
        case (state_d)
          ST_SYN_RCVD, ST_EST: state_d = ST_CLOSE_WAIT;
          ST_FW1:              state_d = head_item_i.ack_flag ? ST_TIME_WAIT : ST_CLOSING;
          ST_FW2:              state_d = ST_TIME_WAIT;
          default:             state_d = state_d;
        endcase
        result_d.action      = ACT_FIN_ACK;
        result_d.user_signal = SIG_CLOSING;
      end else if (!finished) begin
        result_d.action = ACT_PASS;
      end
    end

    result_d.new_state = state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EST;
      una_q       <= '0;
      wnd_q       <= '0;
      wl1_q       <= '0;
      wl2_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        state_q <= state_d;
        una_q   <= una_d;
        wnd_q   <= wnd_d;
        wl1_q   <= wl1_d;
        wl2_q   <= wl2_d;
      end
      // Configuration writes must arrive only while idle; unchecked here.
      if (load_i.state) begin
        state_q <= tsa_state_e'(load_i.value[3:0]);
      end
      if (load_i.una) begin
        una_q <= load_i.value;
      end
      if (load_i.wnd) begin
        wnd_q <= load_i.value[15:0];
      end
      if (load_i.wl1) begin
        wl1_q <= load_i.value;
      end
      if (load_i.wl2) begin
        wl2_q <= load_i.value;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= result_d;
    end
  end

endmodule

// ===== sv/tcp_segment_arrival_fsm.sv =====
// ----------------------------------------------------------------------------
// tcp_segment_arrival_fsm: TCP segment arrival processing, one connection
// Classifies received segments against the receive window, then applies
// RST, SYN, ACK and FIN handling to the connection state.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+--------------------------------------------
//  in      | in_valid_i/in_stall_o  | seg_seq, seg_ack, seg_window, hdr_word,
//          |                        | l4_length
//  out     | out_valid_o/out_stall_i| action, reply_seq, reply_ack, user_signal,
//          |                        | remove_socket, new_state
//  cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i (always ready)
//
// One segment per cycle sustained while the output is not stalled. A
// segment passes through the classifier register, a queue entry and the
// result register before its result shows on the output.
// The back's state update loop through its state registers sets the rate.
// Reset loads the connection state ESTABLISHED and zero send variables.
// A stalled output holds its result; the two queue entries and the classifier
// register take three more items before the input stalls.
//
module tcp_segment_arrival_fsm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] seg_seq_i,
  input  logic [31:0] seg_ack_i,
  input  logic [15:0] seg_window_i,
  input  logic [15:0] hdr_word_i,
  input  logic [15:0] l4_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [31:0] reply_seq_o,
  output logic [31:0] reply_ack_o,
  output logic [2:0]  user_signal_o,
  output logic        remove_socket_o,
  output logic [3:0]  new_state_o
);
  import tsa_pkg::*;

  tsa_cfg_t    cfg_q;
  tsa_load_t   load;
  logic        cfg_we;
  logic        push;
  tsa_item_t   push_item;
  logic        q_full;
  logic        pop;
  logic        head_valid;
  tsa_item_t   head_item;
  tsa_result_t result;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Decode the write into load strobes for the back's state.
  always_comb begin
    load       = '0;
    load.value = cfg_data_i;
    if (cfg_we) begin
      case (tsa_reg_e'(cfg_index_i))
        REG_START_STATE: load.state = 1'b1;
        REG_START_UNA:   load.una   = 1'b1;
        REG_START_WND:   load.wnd   = 1'b1;
        REG_START_WL1:   load.wl1   = 1'b1;
        REG_START_WL2:   load.wl2   = 1'b1;
        default:         load.state = 1'b0;
      endcase
    end
  end

  // Hold the static registers; start values live in the back's state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      case (tsa_reg_e'(cfg_index_i))
        REG_RCV_NEXT:   cfg_q.rcv_next   <= cfg_data_i;
        REG_RCV_WINDOW: cfg_q.rcv_window <= cfg_data_i[15:0];
        REG_SEND_NEXT:  cfg_q.send_next  <= cfg_data_i;
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  tsa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .seg_seq_i    (seg_seq_i),
    .seg_ack_i    (seg_ack_i),
    .seg_window_i (seg_window_i),
    .hdr_word_i   (hdr_word_i),
    .l4_length_i  (l4_length_i),
    .push_o       (push),
    .item_o       (push_item),
    .q_full_i     (q_full)
  );

  tsa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .not_empty_o (head_valid),
    .head_item_o (head_item)
  );

  tsa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .load_i       (load),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result)
  );

  assign action_o        = result.action;
  assign reply_seq_o     = result.reply_seq;
  assign reply_ack_o     = result.reply_ack;
  assign user_signal_o   = result.user_signal;
  assign remove_socket_o = result.remove_socket;
  assign new_state_o     = result.new_state;

endmodule

// ===== sv/tsa_checker.sv =====
// ----------------------------------------------------------------------------
// tsa_checker: port-level checks for tcp_segment_arrival_fsm
// Watches the result channel and the meaning of the result fields.
// ----------------------------------------------------------------------------
module tsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  action_o,
  input logic [31:0] reply_seq_o,
  input logic [31:0] reply_ack_o,
  input logic        remove_socket_o,
  input logic [3:0]  new_state_o
);
  import tsa_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o)
      && $stable(reply_seq_o) && $stable(new_state_o))
    else $error("stalled result changed");

  // Removal always closes the connection and drops the segment.
  a_remove_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && remove_socket_o |->
      new_state_o == ST_CLOSED && action_o == ACT_DROP)
    else $error("removal without close");

  // Reply numbers are only filled for an ACK reply.
  a_reply_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != ACT_ACK |-> reply_seq_o == '0 && reply_ack_o == '0)
    else $error("reply fields set without ACK reply");

  // A listen hand-off, ACK reply or FIN-ACK never removes the connection.
  a_no_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == ACT_LISTEN || action_o == ACT_FIN_ACK
      || action_o == ACT_ACK) |-> !remove_socket_o)
    else $error("removal with reply action");

endmodule

bind tcp_segment_arrival_fsm tsa_checker u_tsa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .action_o        (action_o),
  .reply_seq_o     (reply_seq_o),
  .reply_ack_o     (reply_ack_o),
  .remove_socket_o (remove_socket_o),
  .new_state_o     (new_state_o)
);

// ===== tb/sv/tsa_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// tsa_tb_pkg: segment type and result scoreboard for the arrival testbench
// Holds an independent model of one connection that predicts the result of
// every accepted segment and checks the block's results in order.
// ----------------------------------------------------------------------------
package tsa_tb_pkg;

  import tsa_pkg::*;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] window;
    logic [15:0] hdr;
    logic [15:0] l4_len;
  } segment_t;

  class arrival_scoreboard;
    // Connection parameters.
    logic [31:0] rcv_next;
    logic [15:0] rcv_window;
    logic [31:0] send_next;
    // Connection state.
    logic [3:0]  conn_state;
    logic [31:0] send_unacked;
    logic [15:0] send_window;
    logic [31:0] update_seq;
    logic [31:0] update_ack;

    tsa_result_t predicted_q[$];
    int unsigned errors;
    int unsigned checked;
    logic [15:0] states_seen;

    function new();
      rcv_next     = '0;
      rcv_window   = '0;
      send_next    = '0;
      conn_state   = ST_EST;
      send_unacked = '0;
      send_window  = '0;
      update_seq   = '0;
      update_ack   = '0;
      errors       = 0;
      checked      = 0;
      states_seen  = '0;
    endfunction

    function void write_register(tsa_reg_e idx, logic [31:0] data);
      case (idx)
        REG_RCV_NEXT:    rcv_next = data;
        REG_RCV_WINDOW:  rcv_window = data[15:0];
        REG_SEND_NEXT:   send_next = data;
        REG_START_STATE: conn_state = data[3:0];
        REG_START_UNA:   send_unacked = data;
        REG_START_WND:   send_window = data[15:0];
        REG_START_WL1:   update_seq = data;
        REG_START_WL2:   update_ack = data;
        default: ;
      endcase
    endfunction

    // Modulo-2^32 ordering: a lies strictly behind b.
    function bit older(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
    endfunction

    function bit not_newer(logic [31:0] a, logic [31:0] b);
      return (a == b) || older(a, b);
    endfunction

    function tsa_result_t outcome(tsa_action_e act, logic [31:0] rs, logic [31:0] ra,
                                  tsa_signal_e sig, logic rem);
      tsa_result_t r;
      r.action        = act;
      r.reply_seq     = rs;
      r.reply_ack     = ra;
      r.user_signal   = sig;
      r.remove_socket = rem;
      r.new_state     = conn_state;
      return r;
    endfunction

    function tsa_result_t process_segment(segment_t s);
      logic [3:0]  st;
      logic [31:0] hlen;
      logic [31:0] slen;
      logic [31:0] end_seg;
      logic [31:0] end_win;
      tsa_signal_e sig;
      bit          fin;
      bit          syn;
      bit          rst;
      bit          ackf;
      st   = conn_state;
      fin  = s.hdr[FlagFin];
      syn  = s.hdr[FlagSyn];
      rst  = s.hdr[FlagRst];
      ackf = s.hdr[FlagAck];
      if (st == ST_LISTEN) return outcome(ACT_LISTEN, '0, '0, SIG_NONE, 1'b0);
      if (st == ST_CLOSED || st == ST_SYN_SENT || st > ST_TIME_WAIT)
        return outcome(ACT_DROP, '0, '0, SIG_NONE, 1'b0);

      hlen = {26'd0, s.hdr[15:12], 2'b00};
      if ({16'd0, s.l4_len} < hlen) return outcome(ACT_DROP, '0, '0, SIG_NONE, 1'b0);
      slen = {16'd0, s.l4_len} - hlen;

      end_seg = (slen != 0) ? s.seq + slen - 1 : s.seq;
      if (rcv_window != 0) begin
        end_win = rcv_next + {16'd0, rcv_window};
      end else begin
        if (slen != 0) return outcome(ACT_DROP, '0, '0, SIG_NONE, 1'b0);
        end_win = rcv_next + 1;
      end
      if (!((not_newer(rcv_next, s.seq) && older(s.seq, end_win)) ||
            (not_newer(rcv_next, end_seg) && older(end_seg, end_win))))
        return outcome(ACT_DROP, '0, '0, SIG_NONE, 1'b0);

      if (rst) begin
        if (st == ST_SYN_RCVD) sig = SIG_REFUSED;
        else if (st >= ST_EST && st <= ST_CLOSE_WAIT) sig = SIG_RESET;
        else sig = SIG_INTR;
        conn_state = ST_CLOSED;
        return outcome(ACT_DROP, '0, '0, sig, 1'b1);
      end
      if (syn) begin
        conn_state = ST_CLOSED;
        return outcome(ACT_DROP, '0, '0, SIG_RESET, 1'b1);
      end

      if (ackf) begin
        if (st >= ST_EST && st <= ST_CLOSING) begin
          if (older(send_next, s.ack))
            return outcome(ACT_ACK, rcv_next, send_next, SIG_NONE, 1'b0);
          if (!older(s.ack, send_unacked)) begin
            send_unacked = s.ack;
            if (older(update_seq, s.seq) ||
                (update_seq == s.seq && not_newer(update_ack, s.ack))) begin
              send_window = s.window;
              update_seq  = s.seq;
              update_ack  = s.ack;
            end
            if (st == ST_FW1) conn_state = ST_FW2;
            else if (st == ST_CLOSING) conn_state = ST_TIME_WAIT;
          end
        end else if (st == ST_LAST_ACK) begin
          conn_state = ST_CLOSED;
        end
      end else if (!fin) begin
        return outcome(ACT_DROP, '0, '0, SIG_NONE, 1'b0);
      end

      if (fin) begin
        st = conn_state;
        if (st == ST_SYN_RCVD || st == ST_EST) conn_state = ST_CLOSE_WAIT;
        else if (st == ST_FW1) conn_state = ackf ? ST_TIME_WAIT : ST_CLOSING;
        else if (st == ST_FW2) conn_state = ST_TIME_WAIT;
        return outcome(ACT_FIN_ACK, '0, '0, SIG_CLOSING, 1'b0);
      end
      return outcome(ACT_PASS, '0, '0, SIG_NONE, 1'b0);
    endfunction

    function void note_segment(segment_t s);
      predicted_q.push_back(process_segment(s));
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    endtask

    task check_result(tsa_result_t got);
      tsa_result_t want;
      checked++;
      states_seen[got.new_state] = 1'b1;
      if (predicted_q.size() == 0) begin
        report_mismatch("result with nothing pending", {29'd0, got.action}, '0);
        return;
      end
      want = predicted_q.pop_front();
      if (got.action !== want.action)
        report_mismatch("action", {29'd0, got.action}, {29'd0, want.action});
      if (got.reply_seq !== want.reply_seq)
        report_mismatch("reply_seq", got.reply_seq, want.reply_seq);
      if (got.reply_ack !== want.reply_ack)
        report_mismatch("reply_ack", got.reply_ack, want.reply_ack);
      if (got.user_signal !== want.user_signal)
        report_mismatch("user_signal", {29'd0, got.user_signal}, {29'd0, want.user_signal});
      if (got.remove_socket !== want.remove_socket)
        report_mismatch("remove_socket", {31'd0, got.remove_socket},
                        {31'd0, want.remove_socket});
      if (got.new_state !== want.new_state)
        report_mismatch("new_state", {28'd0, got.new_state}, {28'd0, want.new_state});
    endtask

    task close_out();
      if (predicted_q.size() != 0)
        report_mismatch("results never arrived", predicted_q.size(), '0);
    endtask
  endclass

endpackage

// ===== tb/sv/tb_tcp_segment_arrival_fsm.sv =====
// ----------------------------------------------------------------------------
// tb_tcp_segment_arrival_fsm: self-checking bench for segment arrival
// Drives segment headers through the valid/stall input, programs the
// connection registers between phases, and checks every result against a
// scoreboard that models the connection, under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_tcp_segment_arrival_fsm;

  timeunit 1ns;
  timeprecision 1ps;

  import tsa_pkg::*;
  import tsa_tb_pkg::*;

  // Header word pieces: 20-byte header offset and flag bits.
  localparam logic [15:0] Hdr20  = 16'h5000;
  localparam logic [15:0] HdrFin = 16'h0001 << FlagFin;
  localparam logic [15:0] HdrSyn = 16'h0001 << FlagSyn;
  localparam logic [15:0] HdrRst = 16'h0001 << FlagRst;
  localparam logic [15:0] HdrAck = 16'h0001 << FlagAck;
  localparam logic [15:0] HdrPsh = 16'h0008;

  localparam int unsigned RandomItems = 500;
  // No handshake at all for this long means the block is hung.
  localparam int unsigned IdleLimit   = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] seg_seq;
  logic [31:0] seg_ack;
  logic [15:0] seg_window;
  logic [15:0] hdr_word;
  logic [15:0] l4_length;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  action;
  logic [31:0] reply_seq;
  logic [31:0] reply_ack;
  logic [2:0]  user_signal;
  logic        remove_socket;
  logic [3:0]  new_state;

  arrival_scoreboard board;
  int unsigned       segments_sent;
  int unsigned       random_sent;
  int unsigned       cfg_writes;
  int unsigned       burst_left;

  tcp_segment_arrival_fsm dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .seg_seq_i       (seg_seq),
    .seg_ack_i       (seg_ack),
    .seg_window_i    (seg_window),
    .hdr_word_i      (hdr_word),
    .l4_length_i     (l4_length),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .action_o        (action),
    .reply_seq_o     (reply_seq),
    .reply_ack_o     (reply_ack),
    .user_signal_o   (user_signal),
    .remove_socket_o (remove_socket),
    .new_state_o     (new_state)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Driving tasks. Inputs move on the falling edge; handshakes are judged on
  // the rising edge, where the block sees the same values.
  // --------------------------------------------------------------------------

  // Present one item and hold it until the block takes it.
  task automatic send_segment(input segment_t s);
    @(negedge clk_i);
    in_valid   <= 1'b1;
    seg_seq    <= s.seq;
    seg_ack    <= s.ack;
    seg_window <= s.window;
    hdr_word   <= s.hdr;
    l4_length  <= s.l4_len;
    do @(posedge clk_i); while (in_stall);
    board.note_segment(s);
    segments_sent++;
  endtask

  // Drop valid for the number of cycles given, which must not be zero.
  task automatic pause_input(input int unsigned cycles);
    @(negedge clk_i);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic write_reg(input tsa_reg_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    board.write_register(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every predicted result, then let the pipeline empty out
  // (three stages) before touching the registers.
  task automatic settle();
    while (board.predicted_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic segment_t mk_seg(logic [31:0] seq, logic [31:0] ack,
                                      logic [15:0] win, logic [15:0] hdr,
                                      logic [15:0] len);
    segment_t s;
    s.seq    = seq;
    s.ack    = ack;
    s.window = win;
    s.hdr    = hdr;
    s.l4_len = len;
    return s;
  endfunction

  // Load a connection state, send one item, and drop valid afterwards.
  task automatic directed_case(input logic [3:0] st, input segment_t s);
    settle();
    write_reg(REG_START_STATE, {28'd0, st});
    send_segment(s);
    pause_input(1);
  endtask

  // --------------------------------------------------------------------------
  // Random values.
  // --------------------------------------------------------------------------

  // Sequence-space word biased toward the wrap points.
  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] pick_state();
    int unsigned p;
    p = $urandom_range(0, 19);
    // Mostly synchronized states, so items get past the early drops.
    if (p < 14) return 4'($urandom_range(ST_SYN_RCVD, ST_TIME_WAIT));
    if (p < 16) return 4'($urandom_range(ST_CLOSED, ST_SYN_SENT));
    if (p < 17) return 4'(ST_TIME_WAIT + $urandom_range(1, 5));
    return ST_FW1;
  endfunction

  // Reprogram the connection. State is always reloaded since the last phase
  // may well have closed it; the rest changes at random, or all of it at once.
  task automatic program_connection(input bit all);
    logic [15:0] w;
    if (all || $urandom_range(0, 1)) write_reg(REG_RCV_NEXT, any_word());
    if (all || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 5))
        0: w = 16'h0000;
        1: w = 16'hFFFF;
        2, 3: w = 16'($urandom_range(1, 200));
        default: w = 16'($urandom);
      endcase
      write_reg(REG_RCV_WINDOW, {16'($urandom), w});
    end
    if (all || $urandom_range(0, 1)) write_reg(REG_SEND_NEXT, any_word());
    write_reg(REG_START_STATE, {28'($urandom), pick_state()});
    if (all || $urandom_range(0, 1))
      write_reg(REG_START_UNA, ($urandom_range(0, 9) < 7) ?
                board.send_next - $urandom_range(0, 3000) : any_word());
    if (all || $urandom_range(0, 1)) write_reg(REG_START_WND, $urandom);
    if (all || $urandom_range(0, 1))
      write_reg(REG_START_WL1, ($urandom_range(0, 9) < 7) ?
                board.rcv_next - $urandom_range(0, 500) : any_word());
    if (all || $urandom_range(0, 1))
      write_reg(REG_START_WL2, ($urandom_range(0, 9) < 7) ?
                board.send_unacked - $urandom_range(0, 500) : any_word());
  endtask

  // Well-formed segments near the windows most of the time, noise otherwise.
  function automatic segment_t random_segment();
    segment_t    s;
    logic [3:0]  off;
    logic [31:0] hlen;
    logic [31:0] payload;
    logic [31:0] len;
    logic [31:0] ack_span;
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p < 6) off = 4'd5;
    else if (p < 9) off = 4'($urandom_range(6, 15));
    else off = 4'($urandom_range(0, 4));
    hlen = {26'd0, off, 2'b00};

    p = $urandom_range(0, 19);
    if (p < 12) payload = 0;
    else if (p < 18) payload = $urandom_range(1, 80);
    else payload = $urandom_range(0, 65535);
    len = hlen + payload;
    if (len > 32'hFFFF) len = 32'hFFFF;
    // Truncated segment now and then.
    if ($urandom_range(0, 24) == 0 && hlen != 0) len = $urandom_range(0, hlen - 1);
    s.l4_len = len[15:0];

    p = $urandom_range(0, 19);
    if (p < 8)
      s.seq = board.rcv_next + ((board.rcv_window != 0) ?
              $urandom_range(0, 32'(board.rcv_window) - 1) : 0);
    else if (p < 12) s.seq = board.rcv_next;
    else if (p < 16) s.seq = board.rcv_next - $urandom_range(1, 100);
    else s.seq = $urandom;

    ack_span = board.send_next - board.send_unacked;
    p = $urandom_range(0, 19);
    if (p < 7) s.ack = board.send_next;
    else if (p < 12)
      s.ack = ack_span[31] ? board.send_next
                           : board.send_unacked + $urandom_range(0, ack_span);
    else if (p < 15) s.ack = board.send_unacked - $urandom_range(0, 50);
    else if (p < 17) s.ack = board.send_next + $urandom_range(1, 50);
    else s.ack = $urandom;

    p = $urandom_range(0, 9);
    s.window = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom);

    s.hdr = {off, 12'($urandom)};
    s.hdr[FlagAck] = ($urandom_range(0, 99) < 88);
    s.hdr[FlagFin] = ($urandom_range(0, 99) < 12);
    s.hdr[FlagRst] = ($urandom_range(0, 99) < 3);
    s.hdr[FlagSyn] = ($urandom_range(0, 99) < 2);
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern that changes every stretch of cycles.
  // --------------------------------------------------------------------------
  initial begin : stall_pattern
    int unsigned mode;
    int unsigned stretch;
    mode      = 0;
    stretch   = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stretch == 0) begin
        mode    = $urandom_range(0, 3);
        stretch = $urandom_range(20, 200);
      end
      stretch--;
      case (mode)
        0: out_stall <= 1'b0;                          // free flow
        1: out_stall <= ($urandom_range(0, 3) == 0);   // light stalls
        2: out_stall <= ($urandom_range(0, 3) != 0);   // heavy stalls
        default: out_stall <= ~out_stall;              // alternating stalls
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checking: every taken result goes to the scoreboard.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : sample_result
    tsa_result_t got;
    if (rst_ni && out_valid && !out_stall) begin
      got.action        = tsa_action_e'(action);
      got.reply_seq     = reply_seq;
      got.reply_ack     = reply_ack;
      got.user_signal   = tsa_signal_e'(user_signal);
      got.remove_socket = remove_socket;
      got.new_state     = new_state;
      board.check_result(got);
    end
  end

  // Watchdog: count cycles without any handshake on any channel.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (cfg_valid && cfg_ready) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IdleLimit) begin
        $display("Timeout: no handshake for %0d cycles", IdleLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned n;
    board         = new();
    segments_sent = 0;
    random_sent   = 0;
    cfg_writes    = 0;
    burst_left    = 0;
    rst_ni     = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_RCV_NEXT;
    cfg_data   = '0;
    in_valid   = 1'b0;
    seg_seq    = '0;
    seg_ack    = '0;
    seg_window = '0;
    hdr_word   = '0;
    l4_length  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Receive window straddles the wrap (0xFFFFFFF0 + 0x40),
    // and so does the unacknowledged range (0xFFFFFFF8 .. 0x10).
    write_reg(REG_RCV_NEXT,   32'hFFFF_FFF0);
    write_reg(REG_RCV_WINDOW, 32'h0000_0040);
    write_reg(REG_SEND_NEXT,  32'h0000_0010);
    write_reg(REG_START_UNA,  32'hFFFF_FFF8);
    write_reg(REG_START_WND,  32'h0000_0100);
    write_reg(REG_START_WL1,  32'hFFFF_FFE0);
    write_reg(REG_START_WL2,  32'hFFFF_FFF0);

    // States that never look at the segment.
    directed_case(ST_LISTEN, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h1000, Hdr20 | HdrAck, 16'd20));
    directed_case(ST_CLOSED, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h1000, Hdr20 | HdrAck, 16'd20));
    directed_case(ST_SYN_SENT, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h1000, Hdr20 | HdrAck,
                                      16'd20));
    directed_case(4'(ST_TIME_WAIT + 5), mk_seg(32'hFFFF_FFF0, 32'h10, 16'h1000,
                                               Hdr20 | HdrAck, 16'd20));
    // Length shorter than the header, then a sequence outside the window.
    directed_case(ST_EST, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h1000, Hdr20 | HdrAck, 16'd19));
    directed_case(ST_EST, mk_seg(32'hFFFF_FF00, 32'hFFFF_FFFF, 16'h1000, Hdr20 | HdrAck,
                                 16'd20));
    // Reset from each group of states, and a SYN.
    directed_case(ST_SYN_RCVD, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h0, Hdr20 | HdrRst, 16'd20));
    directed_case(ST_EST, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h0, Hdr20 | HdrRst, 16'd20));
    directed_case(ST_CLOSING, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h0, Hdr20 | HdrRst | HdrAck,
                                     16'd20));
    directed_case(ST_TIME_WAIT, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h0, Hdr20 | HdrRst, 16'd20));
    directed_case(ST_EST, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h0, Hdr20 | HdrSyn, 16'd20));
    // Ack beyond send_next: ACK reply, FIN ignored.
    directed_case(ST_EST, mk_seg(32'hFFFF_FFF0, 32'h11, 16'h0, Hdr20 | HdrAck | HdrFin,
                                 16'd20));
    // Old ack, behind the unacknowledged start, carried with a FIN.
    directed_case(ST_EST, mk_seg(32'hFFFF_FFF0, 32'hFFFF_FFF0, 16'h0,
                                 Hdr20 | HdrAck | HdrFin, 16'd20));
    directed_case(ST_LAST_ACK, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h0, Hdr20 | HdrAck, 16'd20));
    // Neither ACK nor FIN.
    directed_case(ST_EST, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h0, Hdr20 | HdrPsh, 16'd20));
    // FIN handling in the closing states, then an ACK in CLOSING.
    directed_case(ST_FW1, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h0200, Hdr20 | HdrAck | HdrFin,
                                 16'd20));
    directed_case(ST_FW1, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h0, Hdr20 | HdrFin, 16'd20));
    directed_case(ST_FW2, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h0, Hdr20 | HdrFin, 16'd20));
    directed_case(ST_CLOSING, mk_seg(32'h0000_0000, 32'h10, 16'h0, Hdr20 | HdrAck, 16'd20));
    // Field extremes: largest header and length, sequence at both ends.
    directed_case(ST_EST, mk_seg(32'h0000_002F, 32'h10, 16'hFFFF, 16'hF000 | HdrAck,
                                 16'hFFFF));
    directed_case(ST_EST, mk_seg(32'h0000_0000, 32'h0, 16'h0, Hdr20 | HdrAck, 16'd20));
    directed_case(ST_EST, mk_seg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF));
    // Zero receive window: only an empty segment at rcv_next gets in.
    settle();
    write_reg(REG_RCV_WINDOW, 32'h0000_0000);
    directed_case(ST_EST, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h0, Hdr20 | HdrAck, 16'd20));
    directed_case(ST_EST, mk_seg(32'hFFFF_FFF0, 32'h10, 16'h0, Hdr20 | HdrAck, 16'd21));

    // Random phases: reprogram while idle, then a run of segments in bursts.
    settle();
    program_connection(1'b1);
    while (random_sent < RandomItems) begin
      n = $urandom_range(8, 40);
      repeat (n) begin
        if (burst_left == 0) begin
          pause_input($urandom_range(1, 10));
          // Occasional long bursts keep the input saturated for a while.
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 8);
        end
        send_segment(random_segment());
        burst_left--;
        random_sent++;
      end
      pause_input(1);
      settle();
      program_connection($urandom_range(0, 5) == 0);
    end

    // Drain and finish.
    pause_input(1);
    while (board.predicted_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    board.close_out();
    $display("Run covered %0d segments (%0d random) and %0d register writes;",
             segments_sent, random_sent, cfg_writes);
    $display("%0d results checked, %0d connection states seen, %0d mismatches",
             board.checked, $countones(board.states_seen), board.errors);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tsa_pkg.sv
sv/tsa_front.sv
sv/tsa_queue.sv
sv/tsa_back.sv
sv/tcp_segment_arrival_fsm.sv
sv/tsa_checker.sv
tb/sv/tsa_tb_pkg.sv
tb/sv/tb_tcp_segment_arrival_fsm.sv
